/* src/prpb_pkg.sv */
// ----------------------------------------------------------------------------
// prpb_pkg
// shared types, constants and float-order helpers for the probe report parser
// ----------------------------------------------------------------------------
package prpb_pkg;

	localparam int TONE_COUNT_DEF = 64;
	localparam int QUEUE_DEPTH    = 4;
	localparam int QPTR_W         = $clog2(QUEUE_DEPTH);

	localparam logic [7:0]  MAGIC_BYTE = 8'hBC;
	localparam logic [15:0] MIN_TONES  = 16'd3;
	localparam logic [7:0]  ZERO_DB    = 8'd160;
	localparam logic [6:0]  POS_MAX    = 7'd127;

	typedef enum logic [1:0] {
		OP_BYTE,
		OP_LAST,
		OP_READ
	} op_kind_t;

	typedef enum logic [1:0] {
		OUTCOME_NONE,
		OUTCOME_ACCEPT,
		OUTCOME_REJECT
	} outcome_t;

	typedef struct packed {
		op_kind_t    kind;
		logic [7:0]  data;
		logic [5:0]  sel;
		logic        in_range;
	} item_t;

	// maps ieee single bits to an unsigned key in numeric order
	function automatic logic [31:0] order_key(input logic [31:0] bits);
		logic [31:0] b;
		b = (bits[30:0] == 31'd0) ? 32'd0 : bits;
		if (b[31]) begin
			return ~b;
		end
		return b | 32'h8000_0000;
	endfunction

	function automatic logic is_nan(input logic [31:0] bits);
		return (bits[30:23] == 8'hFF) && (bits[22:0] != 23'd0);
	endfunction

endpackage

/* src/prpb_front.sv */
// ----------------------------------------------------------------------------
// prpb_front
// accepts request transactions, classifies them and feeds the queue
// ----------------------------------------------------------------------------
module prpb_front import prpb_pkg::*; #(
	parameter int TONE_COUNT = TONE_COUNT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  logic       req_type,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	input  logic [5:0] tone_select,
	output logic       push,
	output item_t      push_item,
	input  logic       q_full
);

	logic  fe_v_s1;
	item_t fe_item_s1;
	item_t cls;
	logic  accept;

	assign req_stall = fe_v_s1 && q_full;
	assign accept    = req_valid && !req_stall;
	assign push      = fe_v_s1 && !q_full;
	assign push_item = fe_item_s1;

	always_comb begin
		cls.data     = data_byte;
		cls.sel      = tone_select;
		cls.in_range = ({1'b0, tone_select} < 7'(TONE_COUNT));
		if (req_type) begin
			cls.kind = OP_READ;
		end else if (last_byte) begin
			cls.kind = OP_LAST;
		end else begin
			cls.kind = OP_BYTE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fe_v_s1 <= 1'b0;
		end else if (accept) begin
			fe_v_s1 <= 1'b1;
		end else if (push) begin
			fe_v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fe_item_s1 <= cls;
		end
	end

endmodule

/* src/prpb_fifo.sv */
// ----------------------------------------------------------------------------
// prpb_fifo
// short queue of classified items between the front and back parts
// ----------------------------------------------------------------------------
module prpb_fifo import prpb_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output item_t head_item,
	output logic  not_empty
);

	item_t             entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full      = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head_item = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full && !pop |=> count_q == (QPTR_W+1)'(QUEUE_DEPTH))
		else $error("queue count moved while full and not popped");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("queue popped while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QPTR_W+1)'(QUEUE_DEPTH))
		else $error("queue count out of range");

endmodule

/* src/prpb_back.sv */
// ----------------------------------------------------------------------------
// prpb_back
// parses message bytes, commits the record, serves read transactions
// ----------------------------------------------------------------------------
module prpb_back import prpb_pkg::*; #(
	parameter int TONE_COUNT = TONE_COUNT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  item_t             item,
	input  logic              item_valid,
	output logic              item_pop,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output logic              decode_ok,
	output logic              report_valid,
	output logic [31:0]       low_freq_bits,
	output logic [31:0]       high_freq_bits,
	output logic [15:0]       tone_count,
	output logic [63:0]       detected_map,
	output logic [15:0]       capability_flags,
	output logic [7:0]        cyclic_prefix_len,
	output logic [7:0]        pilot_carrier_step,
	output logic [7:0]        pilot_symbol_step,
	output logic [7:0]        fft_size_code,
	output logic signed [8:0] tone_power_half_db
);

	localparam int TONE_W    = (TONE_COUNT > 1) ? $clog2(TONE_COUNT) : 1;
	localparam int ADDR_W    = TONE_W + 1;
	localparam int MEM_DEPTH = 2 << TONE_W;
	localparam int MAP_BYTES = (TONE_COUNT + 7) / 8;
	localparam int HDR_LEN   = 11 + MAP_BYTES;
	localparam int CAPS_END  = HDR_LEN + 2;
	localparam int POWER_END = CAPS_END + TONE_COUNT;
	localparam int PHY_END   = POWER_END + 4;
	localparam logic [63:0] MAP_MASK = {64{1'b1}} >> (64 - TONE_COUNT);

	// parse state
	logic [6:0]  pos_q;
	logic        magic_q;
	logic        bank_q;
	outcome_t    outcome_q;

	// staged fields
	logic [63:0] stg_edges_q;
	logic [15:0] stg_count_q;
	logic [63:0] stg_map_q;
	logic [15:0] stg_caps_q;
	logic [31:0] stg_phy_q;

	// committed record
	logic [63:0] rec_edges_q;
	logic [15:0] rec_count_q;
	logic [63:0] rec_map_q;
	logic [15:0] rec_caps_q;
	logic [31:0] rec_phy_q;
	logic        rec_valid_q;

	// power banks
	logic [7:0]           mem_q [MEM_DEPTH];
	logic [MEM_DEPTH-1:0] mem_vld_q;
	logic                 mem_we;
	logic [ADDR_W-1:0]    waddr;
	logic [ADDR_W-1:0]    raddr;
	logic [6:0]           wk;

	// read stage
	logic        rd_v_s1;
	logic [7:0]  pwr_s1;
	logic        pwr_vld_s1;
	logic        in_range_s1;
	logic        ok_s1;
	logic [63:0] edges_s1;
	logic [15:0] count_s1;
	logic [63:0] map_s1;
	logic [15:0] caps_s1;
	logic [31:0] phy_s1;
	logic        valid_s1;

	// result register
	logic              rsp_valid_q;
	logic              ok_q;
	logic              valid_q;
	logic [63:0]       edges_q;
	logic [15:0]       count_q;
	logic [63:0]       map_q;
	logic [15:0]       caps_q;
	logic [31:0]       phy_q;
	logic [8:0]        power_q;

	logic        is_byte;
	logic        is_read;
	logic        s1_adv;
	logic        do_byte;
	logic        do_commit;
	logic        do_read;
	logic        magic_m;
	logic [7:0]  len_w;
	logic        accept_m;
	logic [63:0] edges_m;
	logic [15:0] count_m;
	logic [63:0] map_m;
	logic [15:0] caps_m;
	logic [31:0] phy_m;
	logic [15:0] caps_c;
	logic [31:0] phy_c;
	logic        valid_c;
	logic [7:0]  pwr_eff;
	logic [8:0]  power_c;

	assign is_byte   = (item.kind == OP_BYTE) || (item.kind == OP_LAST);
	assign is_read   = (item.kind == OP_READ);
	assign s1_adv    = rd_v_s1 && (!rsp_valid_q || !rsp_stall);
	assign item_pop  = item_valid && (is_byte || !rd_v_s1 || s1_adv);
	assign do_byte   = item_pop && is_byte;
	assign do_commit = item_pop && (item.kind == OP_LAST);
	assign do_read   = item_pop && is_read;

	assign len_w    = {1'b0, pos_q} + 8'd1;
	assign magic_m  = (pos_q == '0) ? (item.data == MAGIC_BYTE) : magic_q;
	assign accept_m = (len_w >= 8'(HDR_LEN)) && magic_m;

	// merge the current byte into the staged fields
	always_comb begin
		edges_m = stg_edges_q;
		count_m = stg_count_q;
		map_m   = stg_map_q;
		caps_m  = stg_caps_q;
		phy_m   = stg_phy_q;
		for (int l = 0; l < 8; l++) begin
			if (do_byte && pos_q == 7'(1 + l)) begin
				edges_m[8*l +: 8] = item.data;
			end
			if (do_byte && (l < MAP_BYTES) && pos_q == 7'(11 + l)) begin
				map_m[8*l +: 8] = item.data;
			end
		end
		for (int l = 0; l < 2; l++) begin
			if (do_byte && pos_q == 7'(9 + l)) begin
				count_m[8*l +: 8] = item.data;
			end
			if (do_byte && pos_q == 7'(HDR_LEN + l)) begin
				caps_m[8*l +: 8] = item.data;
			end
		end
		for (int l = 0; l < 4; l++) begin
			if (do_byte && pos_q == 7'(POWER_END + l)) begin
				phy_m[8*l +: 8] = item.data;
			end
		end
	end

	assign caps_c  = (len_w >= 8'(CAPS_END)) ? caps_m : 16'd0;
	assign phy_c   = (len_w >= 8'(PHY_END)) ? phy_m : rec_phy_q;
	assign valid_c = (count_m >= MIN_TONES) && !is_nan(edges_m[31:0]) &&
		!is_nan(edges_m[63:32]) &&
		(order_key(edges_m[63:32]) > order_key(edges_m[31:0]));

	assign wk     = pos_q - 7'(CAPS_END);
	assign mem_we = do_byte && (pos_q >= 7'(CAPS_END)) && (pos_q < 7'(POWER_END));
	assign waddr  = {~bank_q, wk[TONE_W-1:0]};
	assign raddr  = {bank_q, item.sel[TONE_W-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			magic_q     <= 1'b0;
			bank_q      <= 1'b0;
			outcome_q   <= OUTCOME_NONE;
			rec_edges_q <= '0;
			rec_count_q <= '0;
			rec_map_q   <= '0;
			rec_caps_q  <= '0;
			rec_phy_q   <= '0;
			rec_valid_q <= 1'b0;
			mem_vld_q   <= '0;
			rd_v_s1     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (do_commit) begin
				pos_q   <= '0;
				magic_q <= 1'b0;
				if (accept_m) begin
					outcome_q   <= OUTCOME_ACCEPT;
					rec_edges_q <= edges_m;
					rec_count_q <= count_m;
					rec_map_q   <= map_m & MAP_MASK;
					rec_caps_q  <= caps_c;
					rec_phy_q   <= phy_c;
					rec_valid_q <= valid_c;
					if (len_w >= 8'(POWER_END)) begin
						bank_q <= ~bank_q;
					end
				end else begin
					outcome_q <= OUTCOME_REJECT;
				end
			end else if (do_byte) begin
				magic_q <= magic_m;
				if (pos_q != POS_MAX) begin
					pos_q <= pos_q + 7'd1;
				end
			end
			if (mem_we) begin
				mem_vld_q[waddr] <= 1'b1;
			end
			if (do_read) begin
				rd_v_s1 <= 1'b1;
			end else if (s1_adv) begin
				rd_v_s1 <= 1'b0;
			end
			rsp_valid_q <= s1_adv || (rsp_valid_q && rsp_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (do_byte) begin
			stg_edges_q <= edges_m;
			stg_count_q <= count_m;
			stg_map_q   <= map_m;
			stg_caps_q  <= caps_m;
			stg_phy_q   <= phy_m;
		end
		if (mem_we) begin
			mem_q[waddr] <= item.data;
		end
		if (do_read) begin
			pwr_s1      <= mem_q[raddr];
			pwr_vld_s1  <= mem_vld_q[raddr];
			in_range_s1 <= item.in_range;
			ok_s1       <= (outcome_q == OUTCOME_ACCEPT);
			edges_s1    <= rec_edges_q;
			count_s1    <= rec_count_q;
			map_s1      <= rec_map_q;
			caps_s1     <= rec_caps_q;
			phy_s1      <= rec_phy_q;
			valid_s1    <= rec_valid_q;
		end
	end

	assign pwr_eff = pwr_vld_s1 ? pwr_s1 : ZERO_DB;
	assign power_c = in_range_s1 ? ({1'b0, pwr_eff} - {1'b0, ZERO_DB}) : 9'd0;

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			ok_q    <= ok_s1;
			valid_q <= valid_s1;
			edges_q <= edges_s1;
			count_q <= count_s1;
			map_q   <= map_s1;
			caps_q  <= caps_s1;
			phy_q   <= phy_s1;
			power_q <= power_c;
		end
	end

	assign rsp_valid          = rsp_valid_q;
	assign decode_ok          = ok_q;
	assign report_valid       = valid_q;
	assign low_freq_bits      = edges_q[31:0];
	assign high_freq_bits     = edges_q[63:32];
	assign tone_count         = count_q;
	assign detected_map       = map_q;
	assign capability_flags   = caps_q;
	assign cyclic_prefix_len  = phy_q[7:0];
	assign pilot_carrier_step = phy_q[15:8];
	assign pilot_symbol_step  = phy_q[23:16];
	assign fft_size_code      = phy_q[31:24];
	assign tone_power_half_db = $signed(power_q);

	a_pos_clear: assert property (@(posedge clk) disable iff (!arst_n)
		do_commit |=> pos_q == '0 && !magic_q)
		else $error("position not cleared after last byte");
	a_bank_swap: assert property (@(posedge clk) disable iff (!arst_n)
		do_commit && accept_m && (len_w >= 8'(POWER_END)) |=> bank_q != $past(bank_q))
		else $error("power bank not swapped on full commit");
	a_no_collide: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we && do_read |-> waddr != raddr)
		else $error("power write hits the bank being read");
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		rd_v_s1 && !s1_adv |=> rd_v_s1 && $stable(pwr_s1) && $stable(edges_s1))
		else $error("pending read lost its data");

endmodule

/* src/probe_report_byte_parser_unit.sv */
// ----------------------------------------------------------------------------
// probe_report_byte_parser_unit
// throughput: one transaction per cycle, bytes and reads alike, while the queue is not full
// read path: a read passes the front register, the queue, the power bank read register
//   and the result register, in that order
// reset: parse state, committed record and bank select clear at once;
//   power entries read as 0 dB until written, no clearing pass
// ----------------------------------------------------------------------------
module probe_report_byte_parser_unit import prpb_pkg::*; #(
	parameter int TONE_COUNT = TONE_COUNT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  logic              req_type,
	input  logic [7:0]        data_byte,
	input  logic              last_byte,
	input  logic [5:0]        tone_select,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output logic              decode_ok,
	output logic              report_valid,
	output logic [31:0]       low_freq_bits,
	output logic [31:0]       high_freq_bits,
	output logic [15:0]       tone_count,
	output logic [63:0]       detected_map,
	output logic [15:0]       capability_flags,
	output logic [7:0]        cyclic_prefix_len,
	output logic [7:0]        pilot_carrier_step,
	output logic [7:0]        pilot_symbol_step,
	output logic [7:0]        fft_size_code,
	output logic signed [8:0] tone_power_half_db
);

	logic  push;
	item_t push_item;
	logic  q_full;
	logic  pop;
	item_t head_item;
	logic  not_empty;

	prpb_front #(.TONE_COUNT(TONE_COUNT)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req_type    (req_type),
		.data_byte   (data_byte),
		.last_byte   (last_byte),
		.tone_select (tone_select),
		.push        (push),
		.push_item   (push_item),
		.q_full      (q_full)
	);

	prpb_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.head_item (head_item),
		.not_empty (not_empty)
	);

	prpb_back #(.TONE_COUNT(TONE_COUNT)) u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.item               (head_item),
		.item_valid         (not_empty),
		.item_pop           (pop),
		.rsp_valid          (rsp_valid),
		.rsp_stall          (rsp_stall),
		.decode_ok          (decode_ok),
		.report_valid       (report_valid),
		.low_freq_bits      (low_freq_bits),
		.high_freq_bits     (high_freq_bits),
		.tone_count         (tone_count),
		.detected_map       (detected_map),
		.capability_flags   (capability_flags),
		.cyclic_prefix_len  (cyclic_prefix_len),
		.pilot_carrier_step (pilot_carrier_step),
		.pilot_symbol_step  (pilot_symbol_step),
		.fft_size_code      (fft_size_code),
		.tone_power_half_db (tone_power_half_db)
	);

endmodule

/* test/tb_probe_report_byte_parser_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_probe_report_byte_parser_unit
// feeds probe report messages byte by byte, mixed with record reads, and
// checks every readout against a cycle-free model of the parser state;
// covers short, rejected, header-only, tailed and overlong messages with
// random gaps on both handshakes and a long result stall
// ----------------------------------------------------------------------------
module tb_probe_report_byte_parser_unit import prpb_pkg::*; ();

	localparam int TONES       = TONE_COUNT_DEF;
	localparam int MAP_BYTES   = (TONES + 7) / 8;
	localparam int HDR_LEN     = 11 + MAP_BYTES;
	localparam int CAPS_END    = HDR_LEN + 2;
	localparam int POWER_END   = CAPS_END + TONES;
	localparam int PHY_END     = POWER_END + 4;
	localparam int CYCLE_LIMIT = 300000;
	localparam int GAP_MAX     = 10;

	localparam logic        REQ_BYTE = 1'b0;
	localparam logic        REQ_READ = 1'b1;
	localparam logic [63:0] MAP_MASK = (64'd1 << TONES) - 64'd1;

	typedef struct {
		logic        ok;
		logic        valid;
		logic [31:0] lo;
		logic [31:0] hi;
		logic [15:0] count;
		logic [63:0] map;
		logic [15:0] caps;
		logic [31:0] phy;
		logic [8:0]  power;
	} readout_t;

	logic              clk;
	logic              arst_n;
	logic              req_valid;
	logic              req_stall;
	logic              req_type;
	logic [7:0]        data_byte;
	logic              last_byte;
	logic [5:0]        tone_select;
	logic              rsp_valid;
	logic              rsp_stall;
	logic              decode_ok;
	logic              report_valid;
	logic [31:0]       low_freq_bits;
	logic [31:0]       high_freq_bits;
	logic [15:0]       tone_count;
	logic [63:0]       detected_map;
	logic [15:0]       capability_flags;
	logic [7:0]        cyclic_prefix_len;
	logic [7:0]        pilot_carrier_step;
	logic [7:0]        pilot_symbol_step;
	logic [7:0]        fft_size_code;
	logic signed [8:0] tone_power_half_db;

	// parser model state
	int          parse_pos;
	logic        magic_ok;
	logic [63:0] staged_edges;
	logic [15:0] staged_count;
	logic [63:0] staged_map;
	logic [15:0] staged_caps;
	logic [31:0] staged_phy;
	logic [63:0] rec_edges;
	logic [15:0] rec_count;
	logic [63:0] rec_map;
	logic [15:0] rec_caps;
	logic [31:0] rec_phy;
	logic        rec_valid;
	outcome_t    rec_outcome;
	logic [7:0]  power_mem [128];
	logic        live_bank;

	readout_t readouts_due[$];
	int       errors;
	int       items_sent;
	int       rsp_hold_cycles;
	int       cycle_count;
	bit       calm;

	probe_report_byte_parser_unit #(.TONE_COUNT(TONES)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_type(req_type),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.tone_select(tone_select),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.decode_ok(decode_ok),
		.report_valid(report_valid),
		.low_freq_bits(low_freq_bits),
		.high_freq_bits(high_freq_bits),
		.tone_count(tone_count),
		.detected_map(detected_map),
		.capability_flags(capability_flags),
		.cyclic_prefix_len(cyclic_prefix_len),
		.pilot_carrier_step(pilot_carrier_step),
		.pilot_symbol_step(pilot_symbol_step),
		.fft_size_code(fft_size_code),
		.tone_power_half_db(tone_power_half_db)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// high edge strictly above low edge in float order, nan never ordered
	function automatic bit edges_ordered(input logic [31:0] lo, input logic [31:0] hi);
		longint lo_v;
		longint hi_v;
		if ((&lo[30:23] && |lo[22:0]) || (&hi[30:23] && |hi[22:0]))
			return 1'b0;
		lo_v = lo[31] ? -longint'(lo[30:0]) : longint'(lo[30:0]);
		hi_v = hi[31] ? -longint'(hi[30:0]) : longint'(hi[30:0]);
		return hi_v > lo_v;
	endfunction

	function automatic void commit_message(input int len);
		if (len < HDR_LEN || !magic_ok) begin
			rec_outcome = OUTCOME_REJECT;
			return;
		end
		rec_edges = staged_edges;
		rec_count = staged_count;
		rec_caps  = (len >= CAPS_END) ? staged_caps : 16'd0;
		if (len >= PHY_END)
			rec_phy = staged_phy;
		rec_map   = staged_map & MAP_MASK;
		rec_valid = (staged_count >= MIN_TONES) &&
			edges_ordered(staged_edges[31:0], staged_edges[63:32]);
		if (len >= POWER_END)
			live_bank = ~live_bank;
		rec_outcome = OUTCOME_ACCEPT;
	endfunction

	function automatic void predict_transaction(input logic req, input logic [7:0] b,
			input logic last, input logic [5:0] sel);
		int       i;
		readout_t r;
		if (req == REQ_READ) begin
			r.ok    = (rec_outcome == OUTCOME_ACCEPT);
			r.valid = rec_valid;
			r.lo    = rec_edges[31:0];
			r.hi    = rec_edges[63:32];
			r.count = rec_count;
			r.map   = rec_map;
			r.caps  = rec_caps;
			r.phy   = rec_phy;
			r.power = (sel < TONES) ?
				{1'b0, power_mem[(live_bank ? 64 : 0) + sel]} - {1'b0, ZERO_DB} : 9'd0;
			readouts_due = {readouts_due, r};
			return;
		end
		i = parse_pos;
		if (i == 0)
			magic_ok = (b == MAGIC_BYTE);
		else if (i < 9)
			staged_edges[8*(i-1) +: 8] = b;
		else if (i < 11)
			staged_count[8*(i-9) +: 8] = b;
		else if (i < HDR_LEN)
			staged_map[8*(i-11) +: 8] = b;
		else if (i < CAPS_END)
			staged_caps[8*(i-HDR_LEN) +: 8] = b;
		else if (i < POWER_END)
			power_mem[(live_bank ? 0 : 64) + ((i - CAPS_END) & 63)] = b;
		else if (i < PHY_END)
			staged_phy[8*(i-POWER_END) +: 8] = b;
		if (last) begin
			commit_message(i + 1);
			parse_pos = 0;
			magic_ok  = 1'b0;
		end else if (i < POS_MAX) begin
			parse_pos = i + 1;
		end
	endfunction

	task automatic send_item(input logic req, input logic [7:0] b, input logic last,
			input logic [5:0] sel);
		int gap;
		gap = calm ? 0 : $urandom_range(0, GAP_MAX);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid   <= 1'b1;
		req_type    <= req;
		data_byte   <= b;
		last_byte   <= last;
		tone_select <= sel;
		do @(posedge clk); while (req_stall);
		predict_transaction(req, b, last, sel);
		items_sent++;
	endtask

	task automatic send_read();
		send_item(REQ_READ, 8'($urandom), 1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)));
	endtask

	task automatic send_report(input int len, input bit good_magic, input logic [31:0] lo,
			input logic [31:0] hi, input logic [15:0] count, input logic [63:0] map);
		logic [7:0] msg[$];
		logic [7:0] first;
		int         k;
		first = 8'($urandom);
		if (first == MAGIC_BYTE)
			first = ~first;
		msg = {msg, good_magic ? MAGIC_BYTE : first};
		for (k = 0; k < 4; k++) msg = {msg, lo[8*k +: 8]};
		for (k = 0; k < 4; k++) msg = {msg, hi[8*k +: 8]};
		for (k = 0; k < 2; k++) msg = {msg, count[8*k +: 8]};
		for (k = 0; k < MAP_BYTES; k++) msg = {msg, map[8*k +: 8]};
		while (msg.size() < len) msg = {msg, 8'($urandom)};
		for (k = 0; k < len; k++) begin
			if ($urandom_range(0, 7) == 0)
				send_read();
			send_item(REQ_BYTE, msg[k], k == len - 1, 6'($urandom_range(0, 63)));
		end
		send_read();
	endtask

	function automatic logic [31:0] pick_edge();
		case ($urandom_range(0, 9))
			0: return 32'h0000_0000;
			1: return 32'h8000_0000;
			2: return 32'h7F80_0000;
			3: return 32'hFF80_0000;
			4: return {1'($urandom_range(0, 1)), 8'hFF, 22'($urandom), 1'b1};
			5: return 32'h7F7F_FFFF;
			6: return {1'b0, 8'($urandom_range(120, 140)), 23'($urandom)};
			7: return 32'($urandom_range(0, 1)) << 31 | 32'd1;
			default: return $urandom();
		endcase
	endfunction

	function automatic int pick_length();
		case ($urandom_range(0, 9))
			0: return $urandom_range(1, HDR_LEN - 1);
			1: return HDR_LEN + $urandom_range(0, 1);
			2: return $urandom_range(CAPS_END, POWER_END - 1);
			3, 4: return POWER_END;
			5: return $urandom_range(POWER_END + 1, PHY_END - 1);
			6, 7: return PHY_END;
			8: return $urandom_range(PHY_END + 1, 127);
			default: return $urandom_range(128, 140);
		endcase
	endfunction

	task automatic send_random_report();
		logic [31:0] lo;
		logic [31:0] hi;
		logic [15:0] count;
		lo = pick_edge();
		case ($urandom_range(0, 4))
			0: hi = lo;
			1: hi = lo + 32'd1;
			2: hi = lo ^ 32'h8000_0000;
			default: hi = pick_edge();
		endcase
		case ($urandom_range(0, 5))
			0: count = 16'd0;
			1: count = 16'd2;
			2: count = 16'd3;
			3: count = 16'hFFFF;
			default: count = 16'($urandom);
		endcase
		send_report(pick_length(), $urandom_range(0, 9) != 0, lo, hi, count,
			{32'($urandom), 32'($urandom)});
	endtask

	function automatic void check_field(input string name, input logic [63:0] exp,
			input logic [63:0] got);
		if (got !== exp) begin
			$error("%s expected %0h actual %0h", name, exp, got);
			errors++;
		end
	endfunction

	task automatic check_readout();
		readout_t e;
		if (readouts_due.size() == 0) begin
			$error("readout transaction with nothing pending");
			errors++;
			return;
		end
		e = readouts_due.pop_front();
		check_field("decode_ok", e.ok, decode_ok);
		check_field("report_valid", e.valid, report_valid);
		check_field("low_freq_bits", e.lo, low_freq_bits);
		check_field("high_freq_bits", e.hi, high_freq_bits);
		check_field("tone_count", e.count, tone_count);
		check_field("detected_map", e.map, detected_map);
		check_field("capability_flags", e.caps, capability_flags);
		check_field("cyclic_prefix_len", e.phy[7:0], cyclic_prefix_len);
		check_field("pilot_carrier_step", e.phy[15:8], pilot_carrier_step);
		check_field("pilot_symbol_step", e.phy[23:16], pilot_symbol_step);
		check_field("fft_size_code", e.phy[31:24], fft_size_code);
		check_field("tone_power_half_db", e.power, $unsigned(tone_power_half_db));
	endtask

	// result side: per-readout wait, plus a long hold when a test asks for one
	initial begin
		int wait_left;
		wait_left = 0;
		rsp_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_valid && !rsp_stall) begin
				check_readout();
				wait_left = calm ? 0 : $urandom_range(0, GAP_MAX);
			end
			if (rsp_hold_cycles > 0) begin
				rsp_stall <= 1'b1;
				rsp_hold_cycles--;
			end else if (wait_left > 0) begin
				rsp_stall <= 1'b1;
				wait_left--;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	task automatic test_reset_readout();
		send_item(REQ_READ, 8'hFF, 1'b1, 6'd0);
		send_item(REQ_READ, 8'h00, 1'b0, 6'd63);
		send_read();
	endtask

	task automatic test_short_reject();
		send_item(REQ_BYTE, MAGIC_BYTE, 1'b1, 6'd0);
		send_read();
	endtask

	task automatic test_header_only();
		send_report(HDR_LEN, 1'b1, 32'h8000_0000, 32'h0000_0000, 16'hFFFF, {64{1'b1}});
		send_item(REQ_READ, 8'h00, 1'b1, 6'd63);
	endtask

	task automatic test_random_messages(input int item_target);
		int first;
		first = items_sent;
		while (items_sent - first < item_target) begin
			calm = ($urandom_range(0, 4) == 0);
			send_random_report();
		end
		calm = 1'b0;
	endtask

	task automatic test_result_backpressure();
		int k;
		calm = 1'b1;
		rsp_hold_cycles = 200;
		for (k = 0; k < 30; k++) send_read();
		send_report(PHY_END, 1'b1, 32'h4200_0000, 32'h4300_0000, 16'd5, 64'h1234_5678_9ABC_DEF0);
		calm = 1'b0;
	endtask

	task automatic test_drain_pause();
		send_random_report();
		req_valid <= 1'b0;
		do @(posedge clk); while (readouts_due.size() > 0);
		send_random_report();
	endtask

	initial begin
		arst_n      <= 1'b0;
		req_valid   <= 1'b0;
		req_type    <= REQ_BYTE;
		data_byte   <= 8'd0;
		last_byte   <= 1'b0;
		tone_select <= 6'd0;
		parse_pos    = 0;
		magic_ok     = 1'b0;
		staged_edges = '0;
		staged_count = '0;
		staged_map   = '0;
		staged_caps  = '0;
		staged_phy   = '0;
		rec_edges    = '0;
		rec_count    = '0;
		rec_map      = '0;
		rec_caps     = '0;
		rec_phy      = '0;
		rec_valid    = 1'b0;
		rec_outcome  = OUTCOME_NONE;
		live_bank    = 1'b0;
		foreach (power_mem[k]) power_mem[k] = ZERO_DB;
		errors          = 0;
		items_sent      = 0;
		rsp_hold_cycles = 0;
		cycle_count     = 0;
		calm            = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_readout();
		test_short_reject();
		test_header_only();
		test_random_messages(700);
		test_result_backpressure();
		test_drain_pause();
		test_random_messages(700);

		req_valid <= 1'b0;
		do @(posedge clk); while (readouts_due.size() > 0);
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

/* sim.f */
src/prpb_pkg.sv
src/prpb_front.sv
src/prpb_fifo.sv
src/prpb_back.sv
src/probe_report_byte_parser_unit.sv
test/tb_probe_report_byte_parser_unit.sv
